@@ design/wbm_pkg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// wbm_pkg
// Shared types and constants for the word break matcher.
// ----------------------------------------------------------------------------
package wbm_pkg;

    localparam int DICT_WORDS_DEF = 16;
    localparam int WORD_LEN_DEF   = 8;

    typedef enum logic [1:0] {
        KIND_CLEAR = 2'd0,
        KIND_DICT  = 2'd1,
        KIND_TEXT  = 2'd2,
        KIND_NONE  = 2'd3
    } kind_t;

    typedef struct packed {
        logic [1:0] kind;
        logic [7:0] symbol;
        logic       last;
    } in_item_t;

    typedef struct packed {
        logic can_split;
        logic words_dropped;
    } out_item_t;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SCAN,
        ST_DONE
    } eng_state_t;

endpackage

@@ design/word_break_matcher.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// word_break_matcher
// Decides whether a text splits into words of a loaded dictionary.
// ----------------------------------------------------------------------------
// Usage: items enter on in_valid/in_ready (kind, symbol, last). Kind clear
// empties the dictionary and text state, kind dict loads one word character,
// kind text feeds one text character. A text character with last set yields
// one transfer on out_valid/out_ready with can_split and words_dropped.
// A two-entry queue takes items while the engine works. Dictionary, clear
// and ignored items are handled by the engine in its idle state; a text
// character is compared against the stored words one row at a time through
// the single dictionary row read port, until a word fits or the stored
// words run out. The result is registered in the done state after the scan.
// When the receiver stalls the result is held and the engine takes no
// new item until it is taken; the queue keeps accepting up to two.
// Reset empties the dictionary, clears the sticky drop flag and the text
// state; the block is ready as soon as reset is released.
// ----------------------------------------------------------------------------
module word_break_matcher
#(
    parameter int DICT_WORDS = wbm_pkg::DICT_WORDS_DEF,
    parameter int WORD_LEN   = wbm_pkg::WORD_LEN_DEF
)
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                in_valid,
    output logic                in_ready,
    input  wbm_pkg::in_item_t   in_data,
    output logic                out_valid,
    input  logic                out_ready,
    output wbm_pkg::out_item_t  out_data
);
    import wbm_pkg::*;

    logic     q_valid, q_ready;
    in_item_t q_data;

    // intake queue
    wbm_front u_front (
        .clk(clk), .rst_n(rst_n),
        .in_valid(in_valid), .in_ready(in_ready), .in_data(in_data),
        .q_valid(q_valid), .q_ready(q_ready), .q_data(q_data)
    );

    // matching engine
    wbm_engine #(.DICT_WORDS(DICT_WORDS), .WORD_LEN(WORD_LEN)) u_engine (
        .clk(clk), .rst_n(rst_n),
        .q_valid(q_valid), .q_ready(q_ready), .q_data(q_data),
        .out_valid(out_valid), .out_ready(out_ready), .out_data(out_data)
    );

endmodule

@@ design/wbm_front.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// wbm_front
// Two-entry input queue that decouples intake from the matching engine.
// ----------------------------------------------------------------------------
module wbm_front
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    output logic               in_ready,
    input  wbm_pkg::in_item_t  in_data,
    output logic               q_valid,
    input  logic               q_ready,
    output wbm_pkg::in_item_t  q_data
);
    import wbm_pkg::*;

    in_item_t   mem_reg [2];
    logic       wr_ptr_reg, rd_ptr_reg;
    logic [1:0] cnt_reg;
    logic       push, pop;

    assign in_ready = (cnt_reg != 2'd2);
    assign q_valid  = (cnt_reg != 2'd0);
    assign q_data   = mem_reg[rd_ptr_reg];
    assign push     = in_valid && in_ready;
    assign pop      = q_valid && q_ready;

    // queue storage
    always_ff @(posedge clk)
    begin
        if (push)
        begin
            mem_reg[wr_ptr_reg] <= in_data;
        end
    end

    // pointers and fill count
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            cnt_reg    <= 2'd0;
        end
        else
        begin
            if (push) wr_ptr_reg <= ~wr_ptr_reg;
            if (pop)  rd_ptr_reg <= ~rd_ptr_reg;
            cnt_reg <= cnt_reg + {1'b0, push} - {1'b0, pop};
        end
    end

    a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
        cnt_reg == 2'd2 |-> !in_ready) else $error("queue overflow");
    a_cnt_range: assert property (@(posedge clk) disable iff (!rst_n)
        cnt_reg != 2'd3) else $error("bad count");
    a_empty: assert property (@(posedge clk) disable iff (!rst_n)
        cnt_reg == 2'd0 |-> !q_valid) else $error("pop from empty");

endmodule

@@ design/wbm_engine.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// wbm_engine
// Dictionary store and text matcher; scans one stored word per cycle.
// ----------------------------------------------------------------------------
module wbm_engine
#(
    parameter int DICT_WORDS = wbm_pkg::DICT_WORDS_DEF,
    parameter int WORD_LEN   = wbm_pkg::WORD_LEN_DEF
)
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                q_valid,
    output logic                q_ready,
    input  wbm_pkg::in_item_t   q_data,
    output logic                out_valid,
    input  logic                out_ready,
    output wbm_pkg::out_item_t  out_data
);
    import wbm_pkg::*;

    localparam int WB = (DICT_WORDS > 1) ? $clog2(DICT_WORDS) : 1;
    localparam int CB = $clog2(DICT_WORDS + 1);
    localparam int LB = $clog2(WORD_LEN + 1);
    localparam int JB = (WORD_LEN > 1) ? $clog2(WORD_LEN) : 1;

    // dictionary store, one row per word
    logic [WORD_LEN-1:0][7:0] dict_mem [DICT_WORDS];
    logic [WORD_LEN-1:0][7:0] row_rd;
    logic [LB-1:0]  len_reg [DICT_WORDS];
    logic [CB-1:0]  count_reg;
    logic [LB-1:0]  load_len_reg;
    logic           too_long_reg, dropped_reg;
    logic [WORD_LEN-1:0][7:0] win_reg;
    logic [WORD_LEN:0]        hist_reg;
    logic [CB-1:0]  scan_reg;
    logic [LB-1:0]  scan_len_reg;
    logic           found_reg, last_reg, rd_valid_reg;
    eng_state_t     state_reg, state_next;
    out_item_t      out_reg;
    logic           out_valid_reg;

    logic take, is_text, fits, scan_end;
    logic [WB-1:0] scan_rd;

    assign take    = q_valid && q_ready;
    assign is_text = (q_data.kind == KIND_TEXT);
    assign q_ready = (state_reg == ST_IDLE) && !out_valid_reg;
    assign out_valid = out_valid_reg;
    assign out_data  = out_reg;

    // dictionary write and registered row read
    always_ff @(posedge clk)
    begin
        if (take && q_data.kind == KIND_DICT
            && load_len_reg < LB'(WORD_LEN)
            && count_reg < CB'(DICT_WORDS))
        begin
            dict_mem[count_reg[WB-1:0]][load_len_reg[JB-1:0]] <= q_data.symbol;
        end
        row_rd <= dict_mem[scan_rd];
        scan_len_reg <= len_reg[scan_rd];
    end

    // row being fetched; the row compared in a cycle is one behind scan_reg
    assign scan_rd = (state_reg == ST_IDLE || scan_reg >= CB'(DICT_WORDS))
        ? '0 : scan_reg[WB-1:0];

    // compare of the fetched row against the text window
    always_comb
    begin
        fits = (scan_len_reg != '0) && hist_reg[scan_len_reg];
        for (int j = 0; j < WORD_LEN; j++)
        begin
            if (LB'(j) < scan_len_reg
                && row_rd[j] != win_reg[scan_len_reg - LB'(j) - LB'(1)])
            begin
                fits = 1'b0;
            end
        end
        fits = fits && rd_valid_reg;
    end

    assign scan_end = rd_valid_reg
        && ((scan_reg >= count_reg) || fits || found_reg);

    // next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE: if (take && is_text) state_next = ST_SCAN;
            ST_SCAN: if (scan_end || count_reg == '0) state_next = ST_DONE;
            ST_DONE: state_next = ST_IDLE;
            default: state_next = ST_IDLE;
        endcase
    end

    // control and state registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            count_reg     <= '0;
            load_len_reg  <= '0;
            too_long_reg  <= 1'b0;
            dropped_reg   <= 1'b0;
            win_reg       <= '0;
            hist_reg      <= (WORD_LEN+1)'(1);
            scan_reg      <= '0;
            found_reg     <= 1'b0;
            last_reg      <= 1'b0;
            rd_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
            out_reg       <= '0;
            for (int i = 0; i < DICT_WORDS; i++) len_reg[i] <= '0;
        end
        else
        begin
            state_reg <= state_next;
            if (out_valid_reg && out_ready) out_valid_reg <= 1'b0;
            unique case (state_reg)
                ST_IDLE:
                begin
                    rd_valid_reg <= 1'b0;
                    if (take)
                    begin
                        if (q_data.kind == KIND_CLEAR)
                        begin
                            count_reg    <= '0;
                            load_len_reg <= '0;
                            too_long_reg <= 1'b0;
                            dropped_reg  <= 1'b0;
                            win_reg      <= '0;
                            hist_reg     <= (WORD_LEN+1)'(1);
                            for (int i = 0; i < DICT_WORDS; i++) len_reg[i] <= '0;
                        end
                        else if (q_data.kind == KIND_DICT)
                        begin
                            if (q_data.last)
                            begin
                                // drop a word that ran past the row or found no free row
                                if (too_long_reg || load_len_reg >= LB'(WORD_LEN)
                                    || count_reg >= CB'(DICT_WORDS))
                                begin
                                    dropped_reg <= 1'b1;
                                end
                                else
                                begin
                                    len_reg[count_reg[WB-1:0]] <= load_len_reg + LB'(1);
                                    count_reg <= count_reg + CB'(1);
                                end
                                load_len_reg <= '0;
                                too_long_reg <= 1'b0;
                            end
                            else if (load_len_reg < LB'(WORD_LEN))
                            begin
                                load_len_reg <= load_len_reg + LB'(1);
                            end
                            else
                            begin
                                too_long_reg <= 1'b1;
                            end
                        end
                        else if (is_text)
                        begin
                            win_reg  <= (WORD_LEN*8)'({win_reg, q_data.symbol});
                            hist_reg <= {hist_reg[WORD_LEN-1:0], 1'b0};
                            last_reg <= q_data.last;
                            found_reg <= 1'b0;
                            scan_reg <= '0;
                        end
                    end
                end
                ST_SCAN:
                begin
                    rd_valid_reg <= 1'b1;
                    if (fits) found_reg <= 1'b1;
                    scan_reg <= scan_reg + CB'(1);
                end
                ST_DONE:
                begin
                    rd_valid_reg <= 1'b0;
                    if (last_reg)
                    begin
                        out_valid_reg     <= 1'b1;
                        out_reg.can_split <= found_reg;
                        out_reg.words_dropped <= dropped_reg;
                        win_reg  <= '0;
                        hist_reg <= (WORD_LEN+1)'(1);
                    end
                    else
                    begin
                        hist_reg[0] <= found_reg;
                    end
                end
                default: ;
            endcase
        end
    end

    a_out_from_done: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid_reg) |-> $past(state_reg) == ST_DONE)
        else $error("result outside done");
    a_count_max: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CB'(DICT_WORDS)) else $error("count overflow");
    a_no_take_busy: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg != ST_IDLE |-> !q_ready) else $error("take while busy");

endmodule
